// File: rtl/cska_pkg.sv
// ----------------------------------------------------------------------------
// cska_pkg: count-sketch accumulate shared definitions
// Field widths, operation codes and default sizes for the projection engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cska_pkg;

  // Default sizes of the sketch
  localparam int DEF_INPUT_ROWS  = 1024;
  localparam int DEF_NUM_BUCKETS = 64;
  localparam int DEF_NUM_COLUMNS = 8;

  // Item field widths
  localparam int OP_W  = 2;
  localparam int ROW_W = 10;
  localparam int COL_W = 3;
  localparam int BKT_W = 6;
  localparam int VAL_W = 32;
  localparam int SUM_W = 42;

  // Operation codes; code 3 is unused and ignored
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2
  } op_e;

endpackage

`default_nettype wire

// File: rtl/cska_in_if.sv
// ----------------------------------------------------------------------------
// cska_in_if: input item channel
// Valid/ready channel that carries one load, accumulate or read item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cska_in_if;
  logic                                valid;
  logic                                ready;
  logic        [cska_pkg::OP_W-1:0]    operation;
  logic        [cska_pkg::ROW_W-1:0]   row_index;
  logic        [cska_pkg::COL_W-1:0]   column;
  logic        [cska_pkg::BKT_W-1:0]   bucket;
  logic                                negate;
  logic signed [cska_pkg::VAL_W-1:0]   sample_value;

  modport source (
    output valid, operation, row_index, column, bucket, negate, sample_value,
    input  ready
  );
  modport sink (
    input  valid, operation, row_index, column, bucket, negate, sample_value,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/cska_out_if.sv
// ----------------------------------------------------------------------------
// cska_out_if: result item channel
// Valid/ready channel that carries one bucket sum read out of the sketch.
// ----------------------------------------------------------------------------
`default_nettype none

interface cska_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cska_pkg::SUM_W-1:0]   bucket_sum;
  logic        [cska_pkg::BKT_W-1:0]   bucket_echo;

  modport source (
    output valid, bucket_sum, bucket_echo,
    input  ready
  );
  modport sink (
    input  valid, bucket_sum, bucket_echo,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/cska_row_map.sv
// ----------------------------------------------------------------------------
// cska_row_map: row hash table
// Holds the bucket and sign of each input row; one port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cska_row_map #(
  parameter int INPUT_ROWS  = cska_pkg::DEF_INPUT_ROWS,
  parameter int NUM_BUCKETS = cska_pkg::DEF_NUM_BUCKETS,
  localparam int RowAw = $clog2(INPUT_ROWS),
  localparam int BktW  = $clog2(NUM_BUCKETS)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic             wr_en_i,
  input  wire logic [RowAw-1:0] addr_i,
  input  wire logic [BktW-1:0]  wr_bkt_i,
  input  wire logic             wr_neg_i,
  output logic      [BktW-1:0]  rd_bkt_o,
  output logic                  rd_neg_o
);

  logic [BktW:0] mem [INPUT_ROWS];
  logic [BktW:0] rdata_q;

  // Write a loaded entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= {wr_neg_i, wr_bkt_i};
    end
  end

  // Read the entry of the incoming row
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rd_bkt_o = rdata_q[BktW-1:0];
  assign rd_neg_o = rdata_q[BktW];

endmodule

`default_nettype wire

// File: rtl/cska_acc_bank.sv
// ----------------------------------------------------------------------------
// cska_acc_bank: bucket accumulator memory
// Accumulator RAM with a clearing sweep after reset, a registered read and
// forwarding of the write issued at the same edge as the read.
// ----------------------------------------------------------------------------
`default_nettype none

module cska_acc_bank #(
  parameter int NUM_BUCKETS = cska_pkg::DEF_NUM_BUCKETS,
  parameter int NUM_COLUMNS = cska_pkg::DEF_NUM_COLUMNS,
  localparam int Depth = NUM_BUCKETS * NUM_COLUMNS,
  localparam int SlotW = $clog2(Depth)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic [SlotW-1:0]                   rd_slot_i,
  input  wire logic                               wr_en_i,
  input  wire logic [SlotW-1:0]                   wr_slot_i,
  input  wire logic signed [cska_pkg::SUM_W-1:0]  wr_data_i,
  output logic signed [cska_pkg::SUM_W-1:0]       rd_data_o,
  output logic                                    busy_o
);

  logic signed [cska_pkg::SUM_W-1:0] mem [Depth];
  logic signed [cska_pkg::SUM_W-1:0] rdata_q;
  logic signed [cska_pkg::SUM_W-1:0] fwd_q;
  logic                              fwd_hit_q;
  logic                              clr_busy_q;
  logic [SlotW-1:0]                  clr_idx_q;
  logic                              mem_we;
  logic [SlotW-1:0]                  mem_waddr;
  logic signed [cska_pkg::SUM_W-1:0] mem_wdata;

  // Sweep zeros through the memory after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == SlotW'(Depth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Select the sweep or the pipeline write
  always_comb begin
    mem_we    = clr_busy_q | (wr_en_i & en_i);
    mem_waddr = clr_busy_q ? clr_idx_q : wr_slot_i;
    mem_wdata = clr_busy_q ? '0 : wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Read the slot of the next item
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[rd_slot_i];
    end
  end

  // Catch a write to the slot read at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (en_i) begin
      fwd_hit_q <= wr_en_i && (wr_slot_i == rd_slot_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fwd_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_q : rdata_q;
  assign busy_o    = clr_busy_q;

endmodule

`default_nettype wire

// File: rtl/count_sketch_accumulate_unit.sv
// ----------------------------------------------------------------------------
// count_sketch_accumulate_unit: count-sketch projection engine
// Maps rows to signed buckets and accumulates Q16.16 samples into Q26.16 sums.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries load, accumulate and read items; result_o returns one
//   bucket sum for every read item, in order. Both are valid/ready channels.
//   Throughput: one item per cycle while not stalled. An item passes the row
//   table read, the accumulator read, and the add or clear with its write
//   back; a read item's result is then loaded into the result register.
//   Back-to-back accumulates into one slot are served by forwarding the write
//   back into the following read.
//   Reset: row entries are undefined until loaded. The accumulators are
//   cleared by a sweep over all NUM_BUCKETS * NUM_COLUMNS slots (512 by
//   default), during which item_i.ready stays low.
//   Stall: the result register holds a result until taken. Loads and
//   accumulates keep flowing; a read that reaches the write-back stage while
//   the result register is still full holds the pipeline and item_i.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module count_sketch_accumulate_unit #(
  parameter int INPUT_ROWS  = cska_pkg::DEF_INPUT_ROWS,
  parameter int NUM_BUCKETS = cska_pkg::DEF_NUM_BUCKETS,
  parameter int NUM_COLUMNS = cska_pkg::DEF_NUM_COLUMNS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cska_in_if.sink    item_i,
  cska_out_if.source result_o
);

  localparam int RowAw = $clog2(INPUT_ROWS);
  localparam int BktW  = $clog2(NUM_BUCKETS);
  localparam int Depth = NUM_BUCKETS * NUM_COLUMNS;
  localparam int SlotW = $clog2(Depth);

  logic                              advance;
  logic                              accept;
  logic                              busy;
  logic                              row_ok;
  logic                              col_ok;
  logic                              bkt_ok;
  logic                              load_we;

  // First stage
  logic                              p1_valid_q;
  cska_pkg::op_e                     p1_op_q;
  logic                              p1_row_ok_q;
  logic                              p1_col_ok_q;
  logic                              p1_bkt_ok_q;
  logic [cska_pkg::COL_W-1:0]        p1_col_q;
  logic [cska_pkg::BKT_W-1:0]        p1_bkt_q;
  logic signed [cska_pkg::VAL_W-1:0] p1_val_q;
  logic [BktW-1:0]                   tgt;
  logic                              tgt_neg;
  logic                              tgt_ok;
  logic                              p1_acc;
  logic                              p1_res;
  logic                              p1_clr;
  logic [SlotW-1:0]                  p1_slot;
  logic signed [cska_pkg::SUM_W-1:0] val_ext;
  logic signed [cska_pkg::SUM_W-1:0] p1_val;

  // Second stage
  logic                              p2_acc_q;
  logic                              p2_res_q;
  logic                              p2_clr_q;
  logic [SlotW-1:0]                  p2_slot_q;
  logic signed [cska_pkg::SUM_W-1:0] p2_val_q;
  logic [cska_pkg::BKT_W-1:0]        p2_echo_q;
  logic signed [cska_pkg::SUM_W-1:0] old_sum;
  logic signed [cska_pkg::SUM_W-1:0] wr_data;

  // Result register
  logic                              out_valid_q;
  logic signed [cska_pkg::SUM_W-1:0] out_sum_q;
  logic [cska_pkg::BKT_W-1:0]        out_echo_q;

  // Hold everything only when a result meets a full result register
  assign advance = !(p2_res_q && out_valid_q && !result_o.ready);
  assign item_i.ready = advance && !busy;
  assign accept = item_i.valid && item_i.ready;

  // Range checks of the incoming item
  always_comb begin
    row_ok  = 32'(item_i.row_index) < INPUT_ROWS;
    col_ok  = 32'(item_i.column) < NUM_COLUMNS;
    bkt_ok  = 32'(item_i.bucket) < NUM_BUCKETS;
    load_we = accept && (cska_pkg::op_e'(item_i.operation) == cska_pkg::OP_LOAD)
              && row_ok && bkt_ok;
  end

  cska_row_map #(
    .INPUT_ROWS  (INPUT_ROWS),
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_row_map (
    .clk_i    (clk_i),
    .rd_en_i  (advance),
    .wr_en_i  (load_we),
    .addr_i   (RowAw'(item_i.row_index)),
    .wr_bkt_i (BktW'(item_i.bucket)),
    .wr_neg_i (item_i.negate),
    .rd_bkt_o (tgt),
    .rd_neg_o (tgt_neg)
  );

  // Capture the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (advance) begin
      p1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p1_op_q     <= cska_pkg::op_e'(item_i.operation);
      p1_row_ok_q <= row_ok;
      p1_col_ok_q <= col_ok;
      p1_bkt_ok_q <= bkt_ok;
      p1_col_q    <= item_i.column;
      p1_bkt_q    <= item_i.bucket;
      p1_val_q    <= item_i.sample_value;
    end
  end

  // Decode the item and form its accumulator slot and signed value
  always_comb begin
    tgt_ok  = 32'(tgt) < NUM_BUCKETS;
    p1_acc  = p1_valid_q && (p1_op_q == cska_pkg::OP_ACCUM) && p1_row_ok_q
              && p1_col_ok_q && tgt_ok;
    p1_res  = p1_valid_q && (p1_op_q == cska_pkg::OP_READ);
    p1_clr  = p1_res && p1_bkt_ok_q && p1_col_ok_q;
    if (p1_op_q == cska_pkg::OP_READ) begin
      p1_slot = SlotW'(32'(p1_bkt_q) * NUM_COLUMNS + 32'(p1_col_q));
    end else begin
      p1_slot = SlotW'(32'(tgt) * NUM_COLUMNS + 32'(p1_col_q));
    end
    val_ext = cska_pkg::SUM_W'(p1_val_q);
    p1_val  = tgt_neg ? -val_ext : val_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_acc_q <= 1'b0;
      p2_res_q <= 1'b0;
      p2_clr_q <= 1'b0;
    end else if (advance) begin
      p2_acc_q <= p1_acc;
      p2_res_q <= p1_res;
      p2_clr_q <= p1_clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p2_slot_q <= p1_slot;
      p2_val_q  <= p1_val;
      p2_echo_q <= p1_bkt_q;
    end
  end

  // Add the sample, or clear the slot on a read
  assign wr_data = p2_acc_q ? (old_sum + p2_val_q) : '0;

  cska_acc_bank #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_acc_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .rd_slot_i (p1_slot),
    .wr_en_i   (p2_acc_q || p2_clr_q),
    .wr_slot_i (p2_slot_q),
    .wr_data_i (wr_data),
    .rd_data_o (old_sum),
    .busy_o    (busy)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && p2_res_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && p2_res_q) begin
      out_sum_q  <= p2_clr_q ? old_sum : '0;
      out_echo_q <= p2_echo_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.bucket_sum  = out_sum_q;
  assign result_o.bucket_echo = out_echo_q;

  // Pipeline stays empty during the clearing sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (!p1_valid_q && !p2_acc_q && !p2_res_q))
    else $error("item in pipeline during accumulator clear");

  // A stage holds an accumulate or a read, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({p2_acc_q, p2_res_q}))
    else $error("accumulate and read in one stage");

  // A slot clear belongs to a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_clr_q |-> p2_res_q)
    else $error("slot clear without read");

  // An accepted item enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> p1_valid_q)
    else $error("accepted item lost");

endmodule

`default_nettype wire
